@@ rtl/sat_pkg.sv @@
package sat_pkg;

	// table geometry
	localparam int MAX_SECTIONS = 16;
	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// config port geometry
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	// register index, taken from paddr[3]
	localparam logic REG_IMAGE_BASE    = 1'b0;
	localparam logic REG_SECTION_COUNT = 1'b1;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_V2F  = 2'd1;
	localparam logic [1:0] CMD_F2V  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  entry_index;
		logic [31:0] entry_virtual_addr;
		logic [31:0] entry_virtual_size;
		logic [31:0] entry_raw_pointer;
		logic [31:0] entry_raw_size;
		logic [63:0] query_address;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] translated_address;
	} result_t;

	// one section table row
	typedef struct packed {
		logic [31:0] virtual_addr;
		logic [31:0] virtual_size;
		logic [31:0] raw_pointer;
		logic [31:0] raw_size;
	} sect_t;

	localparam int SECT_W = $bits(sect_t);

	typedef enum logic [1:0] {
		JOB_NOP,
		JOB_LOAD,
		JOB_FWD,
		JOB_REV
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [3:0]  idx;
		sect_t       sect;
		logic [63:0] query;
	} job_t;

endpackage

@@ rtl/sat_ram.sv @@
module sat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/sat_front.sv @@
module sat_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  sat_pkg::item_t  item,
	output logic            job_valid,
	input  logic            job_take,
	output sat_pkg::job_t   job
);

	sat_pkg::job_t              job_in;
	sat_pkg::job_t              slot_q [sat_pkg::QUEUE_DEPTH];
	logic [sat_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sat_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sat_pkg::QCNT_W-1:0] cnt_q;
	logic                       wr_ok;
	logic                       rd_ok;

	// classify the incoming word
	always_comb begin
		job_in.idx                = item.entry_index;
		job_in.sect.virtual_addr  = item.entry_virtual_addr;
		job_in.sect.virtual_size  = item.entry_virtual_size;
		job_in.sect.raw_pointer   = item.entry_raw_pointer;
		job_in.sect.raw_size      = item.entry_raw_size;
		job_in.query              = item.query_address;
		unique case (item.cmd)
			sat_pkg::CMD_LOAD: begin
				// slot beyond the table is dropped
				if ($unsigned(32'(item.entry_index)) < $unsigned(32'(sat_pkg::MAX_SECTIONS)))
					job_in.kind = sat_pkg::JOB_LOAD;
				else
					job_in.kind = sat_pkg::JOB_NOP;
			end
			sat_pkg::CMD_V2F: job_in.kind = sat_pkg::JOB_FWD;
			sat_pkg::CMD_F2V: job_in.kind = sat_pkg::JOB_REV;
			default:          job_in.kind = sat_pkg::JOB_NOP;
		endcase
	end

	assign full      = (cnt_q == sat_pkg::QCNT_W'(sat_pkg::QUEUE_DEPTH));
	assign job_valid = (cnt_q != '0);
	assign job       = slot_q[rd_ptr_q];
	assign wr_ok     = push && !full;
	assign rd_ok     = job_take && job_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_ok) begin
				if (wr_ptr_q == sat_pkg::QPTR_W'(sat_pkg::QUEUE_DEPTH - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				if (rd_ptr_q == sat_pkg::QPTR_W'(sat_pkg::QUEUE_DEPTH - 1))
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_ok && !rd_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_ok && !wr_ok)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ rtl/sat_back.sv @@
module sat_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_take,
	input  sat_pkg::job_t     job,
	input  logic [63:0]       image_base,
	input  logic [4:0]        section_count,
	output logic              empty,
	input  logic              pop,
	output sat_pkg::result_t  result
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                     state_q;
	logic                       out_valid_q;
	sat_pkg::result_t           result_q;

	// scan control
	logic                       fwd_q;
	logic [63:0]                query_q;
	logic [sat_pkg::CNT_W-1:0]  n_q;
	logic [sat_pkg::CNT_W-1:0]  n_lim;
	logic [sat_pkg::CNT_W-1:0]  iss_q;
	logic                       out_free;
	logic                       issue;
	logic                       scan_miss;

	// table read
	logic                       wr_en;
	logic [sat_pkg::SECT_W-1:0] rd_data;
	sat_pkg::sect_t             sect_s1;
	logic                       v_s1_q;

	// start and offset base
	logic [64:0]                sum_bv;
	logic                       v_s2_q;
	logic [64:0]                start_s2;
	logic [31:0]                size_s2;
	logic [64:0]                off_s2;

	// distance from start
	logic                       v_s3_q;
	logic [65:0]                diff_s3;
	logic [31:0]                size_s3;
	logic [64:0]                off_s3;

	logic                       match_s3;
	logic [64:0]                res_sum;
	logic [63:0]                res_addr;

	assign out_free = !out_valid_q || pop;
	assign job_take = (state_q == ST_IDLE) && job_valid && out_free;
	assign wr_en    = job_take && (job.kind == sat_pkg::JOB_LOAD);
	assign issue    = (state_q == ST_SCAN) && (iss_q < n_q) && !match_s3;

	// entries searched, clamped to the table
	assign n_lim = ($unsigned(32'(section_count)) > $unsigned(32'(sat_pkg::MAX_SECTIONS)))
		? sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS) : sat_pkg::CNT_W'(section_count);

	sat_ram #(
		.WIDTH(sat_pkg::SECT_W),
		.DEPTH(sat_pkg::MAX_SECTIONS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (sat_pkg::IDX_W'(job.idx)),
		.wr_data (job.sect),
		.rd_en   (issue),
		.rd_addr (iss_q[sat_pkg::IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign sect_s1 = sat_pkg::sect_t'(rd_data);
	assign sum_bv  = {1'b0, image_base} + {33'b0, sect_s1.virtual_addr};

	// match check and answer of the oldest entry in flight
	assign match_s3 = v_s3_q && !diff_s3[65] && (diff_s3[64:32] == '0)
		&& (diff_s3[31:0] < size_s3);
	assign res_sum  = off_s3 + {33'b0, diff_s3[31:0]};
	assign res_addr = res_sum[64] ? '1 : res_sum[63:0];

	// every entry issued and the pipe drained without a match
	assign scan_miss = (state_q == ST_SCAN) && (iss_q >= n_q)
		&& !v_s1_q && !v_s2_q && !v_s3_q;

	// scan payload
	always_ff @(posedge clk) begin
		if (job_take) begin
			fwd_q   <= (job.kind == sat_pkg::JOB_FWD);
			query_q <= job.query;
			n_q     <= n_lim;
		end
		if (fwd_q) begin
			start_s2 <= sum_bv;
			size_s2  <= sect_s1.virtual_size;
			off_s2   <= {33'b0, sect_s1.raw_pointer};
		end else begin
			start_s2 <= {33'b0, sect_s1.raw_pointer};
			size_s2  <= sect_s1.raw_size;
			off_s2   <= sum_bv;
		end
		diff_s3 <= {2'b0, query_q} - {1'b0, start_s2};
		size_s3 <= size_s2;
		off_s3  <= off_s2;
	end

	// issue counter and stage valids, flushed on the first match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= '0;
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			if (job_take)
				iss_q <= '0;
			else if (issue)
				iss_q <= iss_q + 1'b1;
			v_s1_q <= issue;
			v_s2_q <= v_s1_q && !match_s3;
			v_s3_q <= v_s2_q && !match_s3;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_take) begin
						unique case (job.kind) inside
							sat_pkg::JOB_FWD, sat_pkg::JOB_REV: begin
								state_q     <= ST_SCAN;
								out_valid_q <= 1'b0;
							end
							default: begin
								out_valid_q <= 1'b1;
								result_q    <= '0;
							end
						endcase
					end else if (pop) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (match_s3) begin
						out_valid_q                 <= 1'b1;
						result_q.hit                <= 1'b1;
						result_q.translated_address <= res_addr;
						state_q                     <= ST_IDLE;
					end else if (scan_miss) begin
						out_valid_q <= 1'b1;
						result_q    <= '0;
						state_q     <= ST_IDLE;
					end else if (pop) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

endmodule

@@ rtl/section_address_translator_top.sv @@
// a load or an unused command gives its word through the queue slot and the result register
// a translation over n searched sections reads the section table one entry per cycle
// through a three-stage compare and ends at the first match or once all n have drained
// throughput: loads one per cycle while results are popped; no word is taken during a scan
// reset: arst_n clears queue, sequencer, result and config registers; the table is not cleared
module section_address_translator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  sat_pkg::item_t               item,
	output logic                         empty,
	input  logic                         pop,
	output sat_pkg::result_t             result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sat_pkg::PADDR_W-1:0]  paddr,
	input  logic [sat_pkg::PDATA_W-1:0]  pwdata,
	output logic [sat_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	logic [63:0]   image_base_q;
	logic [4:0]    section_count_q;
	logic          cfg_wr;
	logic          job_valid;
	logic          job_take;
	sat_pkg::job_t job;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_base_q    <= '0;
			section_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				sat_pkg::REG_IMAGE_BASE:    image_base_q    <= pwdata;
				sat_pkg::REG_SECTION_COUNT: section_count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3])
			sat_pkg::REG_IMAGE_BASE:    prdata = image_base_q;
			sat_pkg::REG_SECTION_COUNT: prdata = 64'(section_count_q);
			default:                    prdata = '0;
		endcase
	end

	sat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	sat_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job_take      (job_take),
		.job           (job),
		.image_base    (image_base_q),
		.section_count (section_count_q),
		.empty         (empty),
		.pop           (pop),
		.result        (result)
	);

endmodule

@@ rtl/sat_checker.sv @@
module sat_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input sat_pkg::result_t result
);

	// a miss always carries a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.hit |-> result.translated_address == 64'd0)
		else $error("miss word with nonzero address");

	// a waiting word holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result word changed or vanished");

	// the result side only drains through a pop
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result word dropped without pop");

	// the input side only fills through a push
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full raised without push");

endmodule

bind section_address_translator_top sat_checker u_sat_checker (.*);

@@ tb/tb_section_address_translator_top.sv @@
module tb_section_address_translator_top;

	localparam logic [1:0]  CMD_UNUSED     = 2'd3;
	localparam logic [63:0] ALL_ONES       = '1;
	localparam logic [31:0] ONES32         = '1;
	localparam logic [63:0] BASE_TYPICAL   = 64'h0000_0001_4000_0000;
	localparam logic [63:0] BASE_HIGH      = 64'hFFFF_FFFF_0000_0000;
	localparam int          SETTLE_CYCLES  = 30;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          PHASES         = 13;
	localparam int          WORDS_PER_PHASE = 125;

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	sat_pkg::item_t                item;
	logic                          empty;
	logic                          pop;
	sat_pkg::result_t              result;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [sat_pkg::PADDR_W-1:0]   paddr;
	logic [sat_pkg::PDATA_W-1:0]   pwdata;
	logic [sat_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;

	section_address_translator_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// directed stimulus row, optionally reconfiguring before the word goes out
	typedef struct {
		bit               set_cfg;
		logic [63:0]      base;
		logic [4:0]       count;
		sat_pkg::item_t   word;
		bit               typed;
		sat_pkg::result_t want;
	} step_row_t;

	step_row_t directed_rows[$];

	// shadow of the section table and registers
	logic [31:0] sect_va [sat_pkg::MAX_SECTIONS];
	logic [31:0] sect_vs [sat_pkg::MAX_SECTIONS];
	logic [31:0] sect_rp [sat_pkg::MAX_SECTIONS];
	logic [31:0] sect_rs [sat_pkg::MAX_SECTIONS];
	logic [63:0] cfg_base;
	logic [4:0]  cfg_count;

	sat_pkg::result_t pending_results[$];

	bit sender_gaps;
	bit pop_stalls;
	int fail_count;
	int idle_cycles;
	int n_checked;
	int n_settings;
	int n_loads, n_fwd, n_rev, n_unused;
	int n_fwd_hit, n_rev_hit, n_saturated, n_miss;

	always #5 clk = ~clk;

	function automatic int searched_slots();
		return (cfg_count > sat_pkg::MAX_SECTIONS) ? sat_pkg::MAX_SECTIONS : int'(cfg_count);
	endfunction

	// expected word for one accepted input word; loads update the shadow table
	function automatic sat_pkg::result_t translate_word(sat_pkg::item_t w);
		sat_pkg::result_t r;
		logic [64:0]      start;
		logic [64:0]      qx;
		logic [64:0]      sum;
		logic [63:0]      off;
		int               n;
		int               i;
		r = '0;
		n = searched_slots();
		qx = {1'b0, w.query_address};
		case (w.cmd)
			sat_pkg::CMD_LOAD: begin
				n_loads++;
				sect_va[w.entry_index] = w.entry_virtual_addr;
				sect_vs[w.entry_index] = w.entry_virtual_size;
				sect_rp[w.entry_index] = w.entry_raw_pointer;
				sect_rs[w.entry_index] = w.entry_raw_size;
			end
			sat_pkg::CMD_V2F: begin
				n_fwd++;
				for (i = 0; i < n && !r.hit; i++) begin
					start = {1'b0, cfg_base} + {33'd0, sect_va[i]};
					// a section starting past 64 bits never matches
					if (!start[64] && qx >= start && (qx - start) < {33'd0, sect_vs[i]}) begin
						r.hit = 1'b1;
						r.translated_address = {32'd0, sect_rp[i]}
							+ (w.query_address - start[63:0]);
					end
				end
				if (r.hit) n_fwd_hit++;
			end
			sat_pkg::CMD_F2V: begin
				n_rev++;
				for (i = 0; i < n && !r.hit; i++) begin
					off = w.query_address - {32'd0, sect_rp[i]};
					if (w.query_address >= {32'd0, sect_rp[i]} && off < {32'd0, sect_rs[i]}) begin
						r.hit = 1'b1;
						sum = {1'b0, cfg_base} + {33'd0, sect_va[i]} + {1'b0, off};
						// saturate instead of wrapping
						if (sum[64]) begin
							r.translated_address = ALL_ONES;
							n_saturated++;
						end else begin
							r.translated_address = sum[63:0];
						end
					end
				end
				if (r.hit) n_rev_hit++;
			end
			default: n_unused++;
		endcase
		if (!r.hit && (w.cmd == sat_pkg::CMD_V2F || w.cmd == sat_pkg::CMD_F2V)) n_miss++;
		return r;
	endfunction

	function automatic sat_pkg::item_t pack_word(logic [1:0] cmd, logic [3:0] idx,
			logic [31:0] va, logic [31:0] vs, logic [31:0] rp, logic [31:0] rs,
			logic [63:0] q);
		sat_pkg::item_t w;
		w.cmd = cmd;
		w.entry_index = idx;
		w.entry_virtual_addr = va;
		w.entry_virtual_size = vs;
		w.entry_raw_pointer = rp;
		w.entry_raw_size = rs;
		w.query_address = q;
		return w;
	endfunction

	task automatic add_row(bit set_cfg, logic [63:0] base, logic [4:0] count, logic [1:0] cmd,
			logic [3:0] idx, logic [31:0] va, logic [31:0] vs, logic [31:0] rp,
			logic [31:0] rs, logic [63:0] q, bit typed, logic hit, logic [63:0] addr);
		step_row_t row;
		row.set_cfg = set_cfg;
		row.base = base;
		row.count = count;
		row.word = pack_word(cmd, idx, va, vs, rp, rs, q);
		row.typed = typed;
		row.want.hit = hit;
		row.want.translated_address = addr;
		directed_rows.push_back(row);
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (!sender_gaps || roll < 60) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) return 32'd0;
		if (roll < 55) return $urandom_range(1, 4096);
		if (roll < 80) return $urandom_range(1, 32'h0100_0000);
		return $urandom;
	endfunction

	function automatic logic [31:0] rand_place();
		if ($urandom_range(1)) return $urandom;
		return $urandom_range(0, 32'h00FF_F000);
	endfunction

	function automatic logic [63:0] rand_base();
		case ($urandom_range(4))
			0: return 64'd0;
			1: return ALL_ONES;
			2: return {$urandom, $urandom};
			3: return {32'hFFFF_FFFF, $urandom};
			default: return BASE_TYPICAL;
		endcase
	endfunction

	// aim a query at a searched section: inside, at either edge, or just outside; else a random query
	function automatic logic [63:0] aim_query(logic [1:0] cmd);
		logic [63:0] lo;
		logic [31:0] sz;
		logic [31:0] off;
		int          n;
		int          s;
		n = searched_slots();
		if (n == 0 || $urandom_range(99) < 15) return {$urandom, $urandom};
		s = $urandom_range(0, n - 1);
		lo = (cmd == sat_pkg::CMD_V2F) ? cfg_base + {32'd0, sect_va[s]} : {32'd0, sect_rp[s]};
		sz = (cmd == sat_pkg::CMD_V2F) ? sect_vs[s] : sect_rs[s];
		case ($urandom_range(4))
			0: off = 32'd0;
			1: off = sz - 32'd1;
			2: off = sz;
			3: return lo - 64'd1;
			default: off = (sz == 0) ? 32'd0 : $urandom_range(sz - 32'd1);
		endcase
		return lo + {32'd0, off};
	endfunction

	// hand one word to the block, then record what should come back
	task automatic send_word(sat_pkg::item_t w, bit typed, sat_pkg::result_t want);
		int               gap;
		sat_pkg::result_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		pred = translate_word(w);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic write_reg(logic sel, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == sat_pkg::REG_IMAGE_BASE) cfg_base = value;
		else cfg_count = value[4:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// let the block go idle, then load both registers
	task automatic reconfigure(logic [63:0] base, logic [4:0] count);
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(sat_pkg::REG_IMAGE_BASE, base);
		write_reg(sat_pkg::REG_SECTION_COUNT, {59'd0, count});
		n_settings++;
	endtask

	// result side: random pop with occasional long stalls, or pop held high when stalls are off
	initial begin : pop_driver
		int stall_left;
		int roll;
		stall_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			roll = $urandom_range(99);
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!pop_stalls) begin
				pop <= 1'b1;
			end else if (roll < 4) begin
				stall_left = $urandom_range(10, 40);
				pop <= 1'b0;
			end else begin
				pop <= (roll >= 30);
			end
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		sat_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				$error("unexpected word: hit %0d translated_address %h",
					result.hit, result.translated_address);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, result.hit);
					fail_count++;
				end
				if (result.translated_address !== want.translated_address) begin
					$error("translated_address: expected %h, got %h",
						want.translated_address, result.translated_address);
					fail_count++;
				end
			end
		end
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_section_address_translator_top failed");
				$finish;
			end
		end
	end

	initial begin : main
		sat_pkg::result_t none;
		sat_pkg::item_t   w;
		int               ph;
		int               k;
		int               roll;
		logic [1:0]       cmd;
		logic [63:0]      base;
		logic [4:0]       count;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_base = '0;
		cfg_count = '0;
		sender_gaps = 1'b1;
		pop_stalls = 1'b1;
		fail_count = 0;
		idle_cycles = 0;
		none = '0;

		// after reset: nothing searched, so every query misses
		add_row(1, 64'd0, 5'd0, CMD_UNUSED, 4'hF, ONES32, ONES32, ONES32, ONES32, ALL_ONES,
			1, 1'b0, 64'd0);
		add_row(0, 0, 0, sat_pkg::CMD_V2F, 4'h0, 0, 0, 0, 0, 64'd0, 1, 1'b0, 64'd0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 4'h0, 0, 0, 0, 0, ALL_ONES, 1, 1'b0, 64'd0);
		// loads: a plain section, an empty one, one at the extremes, one overlapping, one in the last slot
		add_row(0, 0, 0, sat_pkg::CMD_LOAD, 4'h0, 32'h1000, 32'h200, 32'h400, 32'h200,
			ALL_ONES, 1, 1'b0, 64'd0);
		add_row(0, 0, 0, sat_pkg::CMD_LOAD, 4'h1, 0, 0, 0, 0, 64'd0, 1, 1'b0, 64'd0);
		add_row(0, 0, 0, sat_pkg::CMD_LOAD, 4'h2, ONES32, ONES32, ONES32, ONES32, 64'd0,
			1, 1'b0, 64'd0);
		add_row(0, 0, 0, sat_pkg::CMD_LOAD, 4'h3, 32'h1100, 32'h1000, 32'h8000, 32'h100,
			64'd0, 1, 1'b0, 64'd0);
		add_row(0, 0, 0, sat_pkg::CMD_LOAD, 4'hF, 32'hA5A5_5A5A, 32'h10, 32'h5A5A_A5A5,
			32'h10, ALL_ONES, 1, 1'b0, 64'd0);
		// ordinary base, four sections searched
		add_row(1, BASE_TYPICAL, 5'd4, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0,
			BASE_TYPICAL + 64'h1000, 1, 1'b1, 64'h400);
		add_row(0, 0, 0, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0, BASE_TYPICAL + 64'h11FF, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0, BASE_TYPICAL + 64'h1200, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0, BASE_TYPICAL + 64'h0FFF, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0, BASE_TYPICAL + 64'hFFFF_FFFF,
			0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'h400, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'h80FF, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'd0, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'h1_FFFF_FFFE, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'h1_FFFF_FFFD, 0, 0, 0);
		// base of all ones: starts overflow, reverse answers saturate
		add_row(1, ALL_ONES, 5'd4, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0, ALL_ONES, 1, 1'b0, 64'd0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'h400, 1, 1'b1, ALL_ONES);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'hFFFF_FFFF, 1, 1'b1, ALL_ONES);
		// base near the top without overflow
		add_row(1, BASE_HIGH, 5'd4, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0, BASE_HIGH + 64'h1000,
			0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_F2V, 0, 0, 0, 0, 0, 64'h401, 0, 0, 0);
		add_row(0, 0, 0, sat_pkg::CMD_V2F, 0, 0, 0, 0, 0, ALL_ONES, 0, 0, 0);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].set_cfg)
				reconfigure(directed_rows[k].base, directed_rows[k].count);
			send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].want);
		end

		// fill every slot so any section count is safe to search
		for (k = 0; k < sat_pkg::MAX_SECTIONS; k++) begin
			w = pack_word(sat_pkg::CMD_LOAD, k[3:0], rand_place(), rand_size(), rand_place(),
				rand_size(), {$urandom, $urandom});
			send_word(w, 0, none);
		end

		// random phases, each under its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin base = 64'd0; count = 5'd16; end
				1: begin base = ALL_ONES; count = 5'd31; end
				2: begin base = BASE_HIGH; count = 5'd0; end
				default: begin
					base = rand_base();
					count = ($urandom_range(3) == 0) ? 5'($urandom_range(17, 31))
						: 5'($urandom_range(1, 16));
				end
			endcase
			reconfigure(base, count);
			sender_gaps = (ph % 3 != 0);
			pop_stalls = (ph % 4 != 0);
			for (k = 0; k < WORDS_PER_PHASE; k++) begin
				roll = $urandom_range(99);
				if (roll < 15) cmd = sat_pkg::CMD_LOAD;
				else if (roll < 55) cmd = sat_pkg::CMD_V2F;
				else if (roll < 93) cmd = sat_pkg::CMD_F2V;
				else cmd = CMD_UNUSED;
				w = pack_word(cmd, 4'($urandom_range(15)), rand_place(), rand_size(),
					rand_place(), rand_size(), {$urandom, $urandom});
				if (cmd == sat_pkg::CMD_V2F || cmd == sat_pkg::CMD_F2V)
					w.query_address = aim_query(cmd);
				send_word(w, 0, none);
			end
		end

		// wait out everything still in flight
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d loads, %0d forward, %0d reverse, %0d unused words over %0d settings",
			n_loads, n_fwd, n_rev, n_unused, n_settings);
		$display("checked %0d words: %0d forward hits, %0d reverse hits, %0d saturated, %0d misses",
			n_checked, n_fwd_hit, n_rev_hit, n_saturated, n_miss);
		if (fail_count == 0) begin
			$display("tb_section_address_translator_top passed");
		end else begin
			$display("tb_section_address_translator_top failed");
		end
		$finish;
	end

endmodule
